>>> src/lcp_pkg.sv
// Shared types, constants and sensor bias table for the line centroid PID core.
// No dependencies.
package lcp_pkg;

    localparam int NUM_SENSORS     = 8;
    localparam int SENSOR_BITS_DEF = 12;
    localparam int CFG_IDX_W       = 3;
    localparam int DVD_W           = 48;
    localparam int DVS_W           = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P = 3'd0,
        CFG_GAIN_I = 3'd1,
        CFG_GAIN_D = 3'd2,
        CFG_TARGET = 3'd3,
        CFG_PERIOD = 3'd4,
        CFG_LIMIT  = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MERGE,
        ST_CENT,
        ST_CWAIT,
        ST_ERR,
        ST_INT_MUL,
        ST_INT_ACC,
        ST_P_DT,
        ST_D_MUL,
        ST_D_ACC,
        ST_I_DT,
        ST_I_ACC,
        ST_TDIV,
        ST_TWAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic [7:0] sensor_bias(input int idx);
        logic [7:0] b;
        b = 8'd96;
        if (idx == 0) b = 8'd146;
        if (idx == 7) b = 8'd122;
        return b;
    endfunction

endpackage

>>> src/lcp_lane.sv
// One sensor lane: bias removal and half-weight IIR filter state.
// Depends on lcp_pkg.
module lcp_lane import lcp_pkg::*; #(
    parameter int SENSOR_BITS = SENSOR_BITS_DEF,
    parameter int LANE        = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic                           i_preload,
    input  logic [SENSOR_BITS-1:0]         i_raw,
    output logic signed [SENSOR_BITS+1:0]  o_level
);

    localparam int LW = SENSOR_BITS + 2;

    logic signed [LW-1:0] r_level;
    logic signed [LW-1:0] w_biased;
    logic signed [LW:0]   w_sum;
    logic signed [LW-1:0] n_level;

    assign w_biased = $signed({2'b00, i_raw}) - $signed({{(LW-8){1'b0}}, sensor_bias(LANE)});
    assign w_sum    = {w_biased[LW-1], w_biased} + {r_level[LW-1], r_level};

    always_comb begin
        n_level = r_level;
        if (i_load) begin
            n_level = i_preload ? w_biased : w_sum[LW:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else begin
            r_level <= n_level;
        end
    end

    assign o_level = r_level;

endmodule

>>> src/lcp_merge.sv
// Merging stage: registered weighted sum and plain sum over all lanes.
// Depends on lcp_pkg.
module lcp_merge import lcp_pkg::*; #(
    parameter int SENSOR_BITS = SENSOR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic signed [SENSOR_BITS+1:0] i_level [NUM_SENSORS],
    output logic signed [SENSOR_BITS+7:0] o_num,
    output logic signed [SENSOR_BITS+4:0] o_den
);

    localparam int NW = SENSOR_BITS + 8;
    localparam int DW = SENSOR_BITS + 5;

    logic signed [NW-1:0] n_num;
    logic signed [DW-1:0] n_den;
    logic signed [NW-1:0] r_num;
    logic signed [DW-1:0] r_den;

    always_comb begin
        n_num = '0;
        n_den = '0;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            n_num = n_num + NW'(i_level[i]) * NW'(i);
            n_den = n_den + DW'(i_level[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_den <= n_den;
    end

    assign o_num = r_num;
    assign o_den = r_den;

endmodule

>>> src/lcp_divider.sv
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on lcp_pkg.
module lcp_divider import lcp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output t_div_stat        o_stat,
    output logic [DVD_W-1:0] o_quot,
    output logic [DVS_W-1:0] o_rem
);

    localparam int CW = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DVD_W-1:0] r_quot;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_quot[DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DVD_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;
    assign o_rem       = r_rem;

endmodule

>>> src/line_centroid_pid_steering_core.sv
// Top level: sensor lanes, merge stage, shared divider and the PID sequencer.
// Depends on lcp_pkg, lcp_lane, lcp_merge, lcp_divider.
//
//  channel   handshake                 payload
//  input     i_valid / o_ready         i_operation, i_sensor_0..7, i_feed_speed
//  result    o_valid / i_ready         o_turn_rate, o_forward_speed, o_line_position, o_no_line
//  config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A start beat is accepted in the idle state and its result is registered directly, without
// the sequencer. A sample beat with a line runs two 48-step divider passes (centroid,
// turn rate) plus the merge, multiply and clamp steps.
// With no line the centroid division is skipped.
// Reset is synchronous and clears filters, integral and history; no clearing pass.
// A result waiting on i_ready holds o_ready low and holds a finished sample in its last step.
module line_centroid_pid_steering_core import lcp_pkg::*; #(
    parameter int SENSOR_BITS = SENSOR_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_operation,
    input  logic [SENSOR_BITS-1:0] i_sensor_0,
    input  logic [SENSOR_BITS-1:0] i_sensor_1,
    input  logic [SENSOR_BITS-1:0] i_sensor_2,
    input  logic [SENSOR_BITS-1:0] i_sensor_3,
    input  logic [SENSOR_BITS-1:0] i_sensor_4,
    input  logic [SENSOR_BITS-1:0] i_sensor_5,
    input  logic [SENSOR_BITS-1:0] i_sensor_6,
    input  logic [SENSOR_BITS-1:0] i_sensor_7,
    input  logic [15:0]            i_feed_speed,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic signed [31:0]     o_turn_rate,
    output logic [15:0]            o_forward_speed,
    output logic signed [15:0]     o_line_position,
    output logic                   o_no_line,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]            i_cfg_data
);

    localparam int LW = SENSOR_BITS + 2;
    localparam int NW = SENSOR_BITS + 8;
    localparam int DW = SENSOR_BITS + 5;

    logic [19:0] r_gain_p, r_gain_i, r_gain_d;
    logic [15:0] r_target;
    logic [9:0]  r_period;
    logic [30:0] r_limit;

    t_state r_state, n_state;
    logic   r_ov;

    logic signed [31:0] r_turn;
    logic [15:0]        r_speed;
    logic signed [15:0] r_pos;
    logic               r_nol;

    logic [15:0]        r_spd_cur;
    logic signed [15:0] r_pos_cur;
    logic               r_nol_cur;
    logic signed [16:0] r_err;
    logic signed [16:0] r_prev;
    logic signed [31:0] r_integ;
    logic signed [15:0] r_held;
    logic signed [63:0] r_mul;
    logic signed [65:0] r_acc;
    logic               r_neg;

    logic                   w_accept;
    logic                   w_out_free;
    logic [SENSOR_BITS-1:0] w_raw [NUM_SENSORS];
    logic signed [LW-1:0]   w_level [NUM_SENSORS];
    logic signed [NW-1:0]   w_num;
    logic signed [DW-1:0]   w_den;
    logic [9:0]             w_dt;
    logic signed [10:0]     w_dts;

    logic             w_div_start;
    logic [DVD_W-1:0] w_dvd;
    logic [DVS_W-1:0] w_dvs;
    t_div_stat        w_div;
    logic [DVD_W-1:0] w_quot;
    logic [DVS_W-1:0] w_rem;
    logic signed [DVD_W+1:0] w_qs;

    logic signed [NW:0]   w_num_abs;
    logic signed [65:0]   w_tx;
    logic signed [65:0]   w_tx_abs;
    logic signed [17:0]   w_err_raw;
    logic signed [39:0]   w_int_sum;
    logic signed [39:0]   w_lim;

    assign w_raw[0] = i_sensor_0;
    assign w_raw[1] = i_sensor_1;
    assign w_raw[2] = i_sensor_2;
    assign w_raw[3] = i_sensor_3;
    assign w_raw[4] = i_sensor_4;
    assign w_raw[5] = i_sensor_5;
    assign w_raw[6] = i_sensor_6;
    assign w_raw[7] = i_sensor_7;

    assign w_out_free = !r_ov || i_ready;
    assign w_accept   = i_valid && o_ready;
    assign w_dt       = (r_period == '0) ? 10'd1 : r_period;
    assign w_dts      = $signed({1'b0, w_dt});

    for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
        lcp_lane #(.SENSOR_BITS(SENSOR_BITS), .LANE(g)) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_load    (w_accept),
            .i_preload (!i_operation),
            .i_raw     (w_raw[g]),
            .o_level   (w_level[g])
        );
    end

    lcp_merge #(.SENSOR_BITS(SENSOR_BITS)) u_merge (
        .i_clk   (i_clk),
        .i_level (w_level),
        .o_num   (w_num),
        .o_den   (w_den)
    );

    lcp_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_stat     (w_div),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // divider operands
    assign w_num_abs = w_num[NW-1] ? -(NW+1)'(w_num) : (NW+1)'(w_num);
    assign w_tx      = (-r_acc) >>> 20;
    assign w_tx_abs  = w_tx[65] ? -w_tx : w_tx;

    always_comb begin
        if (r_state == ST_CENT) begin
            w_dvd = DVD_W'(w_num_abs) << 10;
            w_dvs = DVS_W'(DW'(w_den) * DW'(5));
        end else begin
            w_dvd = DVD_W'(w_tx_abs);
            w_dvs = DVS_W'(w_dt);
        end
    end

    // floor quotient from magnitude
    assign w_qs = r_neg ? (-$signed({2'b00, w_quot}) - $signed((DVD_W+2)'(w_rem != '0)))
                        : $signed({2'b00, w_quot});

    assign w_err_raw = 18'(r_pos_cur) - $signed({2'b00, r_target});
    assign w_int_sum = 40'(r_integ) + 40'(r_mul <<< 8);
    assign w_lim     = $signed({9'd0, r_limit});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (w_accept && i_operation) n_state = ST_MERGE;
            ST_MERGE:   n_state = ST_CENT;
            ST_CENT:    n_state = (!w_den[DW-1] && w_den != '0) ? ST_CWAIT : ST_ERR;
            ST_CWAIT:   if (w_div.done) n_state = ST_ERR;
            ST_ERR:     n_state = ST_INT_MUL;
            ST_INT_MUL: n_state = ST_INT_ACC;
            ST_INT_ACC: n_state = ST_P_DT;
            ST_P_DT:    n_state = ST_D_MUL;
            ST_D_MUL:   n_state = ST_D_ACC;
            ST_D_ACC:   n_state = ST_I_DT;
            ST_I_DT:    n_state = ST_I_ACC;
            ST_I_ACC:   n_state = ST_TDIV;
            ST_TDIV:    n_state = ST_TWAIT;
            ST_TWAIT:   if (w_div.done) n_state = ST_DONE;
            ST_DONE:    if (w_out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_ready     = 1'b0;
        w_div_start = 1'b0;
        case (r_state)
            ST_IDLE: o_ready     = w_out_free;
            ST_CENT: w_div_start = !w_den[DW-1] && w_den != '0;
            ST_TDIV: w_div_start = 1'b1;
            default: ;
        endcase
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ov     <= 1'b0;
            r_gain_p <= 20'd65536;
            r_gain_i <= 20'd82;
            r_gain_d <= 20'd2048;
            r_target <= 16'd717;
            r_period <= 10'd10;
            r_limit  <= 31'd3276800;
            r_prev   <= '0;
            r_integ  <= '0;
            r_held   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_GAIN_P: r_gain_p <= i_cfg_data[19:0];
                    CFG_GAIN_I: r_gain_i <= i_cfg_data[19:0];
                    CFG_GAIN_D: r_gain_d <= i_cfg_data[19:0];
                    CFG_TARGET: r_target <= i_cfg_data[15:0];
                    CFG_PERIOD: r_period <= i_cfg_data[9:0];
                    CFG_LIMIT:  r_limit  <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept && !i_operation) begin
                        r_integ <= '0;
                        r_ov    <= 1'b1;
                    end
                end
                ST_CWAIT: begin
                    if (w_div.done) begin
                        if (w_qs > 50'sd32767) r_held <= 16'sh7FFF;
                        else if (w_qs < -50'sd32768) r_held <= -16'sh8000;
                        else r_held <= 16'(w_qs);
                    end
                end
                ST_INT_ACC: begin
                    if (w_int_sum > w_lim) r_integ <= 32'(w_lim);
                    else if (w_int_sum < -w_lim) r_integ <= 32'(-w_lim);
                    else r_integ <= 32'(w_int_sum);
                end
                ST_I_ACC: r_prev <= r_err;
                ST_DONE:  if (w_out_free) r_ov <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_spd_cur <= i_feed_speed;
                    if (!i_operation) begin
                        r_turn  <= '0;
                        r_speed <= i_feed_speed;
                        r_pos   <= r_held;
                        r_nol   <= 1'b0;
                    end
                end
            end
            ST_CENT: begin
                r_neg     <= w_num[NW-1];
                r_pos_cur <= r_held;
                r_nol_cur <= !(!w_den[DW-1] && w_den != '0);
            end
            ST_CWAIT: begin
                if (w_div.done) begin
                    if (w_qs > 50'sd32767) r_pos_cur <= 16'sh7FFF;
                    else if (w_qs < -50'sd32768) r_pos_cur <= -16'sh8000;
                    else r_pos_cur <= 16'(w_qs);
                end
            end
            ST_ERR: begin
                if (w_err_raw > 18'sd65535) r_err <= 17'sh0FFFF;
                else if (w_err_raw < -18'sd65536) r_err <= -17'sh10000;
                else r_err <= 17'(w_err_raw);
            end
            ST_INT_MUL: r_mul <= 64'(r_err * w_dts);
            ST_INT_ACC: r_mul <= 64'(r_err * $signed({1'b0, r_gain_p}));
            ST_P_DT:    r_acc <= 66'(r_mul * w_dts) <<< 8;
            ST_D_MUL:   r_mul <= 64'((18'(r_err) - 18'(r_prev)) * $signed({1'b0, r_gain_d}));
            ST_D_ACC: begin
                r_acc <= r_acc + (66'(r_mul) <<< 8);
                r_mul <= 64'(r_integ * $signed({1'b0, r_gain_i}));
            end
            ST_I_DT:    r_mul <= 64'(r_mul * w_dts);
            ST_I_ACC:   r_acc <= r_acc + 66'(r_mul);
            ST_TDIV:    r_neg <= w_tx[65];
            ST_TWAIT: begin
                if (w_div.done) begin
                    if (w_qs > 50'sh0_7FFF_FFFF) r_mul <= 64'sh7FFF_FFFF;
                    else if (w_qs < -50'sh0_8000_0000) r_mul <= -64'sh8000_0000;
                    else r_mul <= 64'(w_qs);
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    r_turn  <= 32'(r_mul);
                    r_speed <= r_spd_cur;
                    r_pos   <= r_pos_cur;
                    r_nol   <= r_nol_cur;
                end
            end
            default: ;
        endcase
    end

    assign o_valid         = r_ov;
    assign o_turn_rate     = r_turn;
    assign o_forward_speed = r_speed;
    assign o_line_position = r_pos;
    assign o_no_line       = r_nol;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (r_state == ST_IDLE))
        else $error("input taken while busy");
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div.busy)
        else $error("divider restarted while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> (r_ov && $stable(o_turn_rate) && $stable(o_line_position)))
        else $error("pending result overwritten");
`endif

endmodule

>>> test/tb_line_centroid_pid_steering_core.sv
// Self-checking testbench for line_centroid_pid_steering_core: directed and random
// sensor beats under varied gains, idling and back-pressure, checked by a local predictor.
// Depends on lcp_pkg and the core RTL.
module tb_line_centroid_pid_steering_core import lcp_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum bit {OP_START = 1'b0, OP_SAMPLE = 1'b1} t_op;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
    localparam int BIAS [8] = '{146, 96, 96, 96, 96, 96, 96, 122};
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;

    typedef struct {
        t_op         op;
        logic [11:0] sens [8];
        logic [15:0] speed;
    } t_beat;

    typedef struct {
        logic signed [31:0] turn;
        logic [15:0]        speed;
        logic signed [15:0] pos;
        logic               no_line;
    } t_steer;

    logic clk = 1'b0, rst_n = 1'b0;
    logic in_valid = 1'b0, in_op = 1'b0, out_ready = 1'b0;
    logic [11:0] sens [8] = '{default: '0};
    logic [15:0] speed_in = '0;
    logic cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [31:0] cfg_data = '0;
    logic o_ready, o_valid, o_no_line, o_cfg_ready;
    logic signed [31:0] o_turn_rate;
    logic [15:0] o_forward_speed;
    logic signed [15:0] o_line_position;

    t_beat  beat_q [$];
    t_steer steer_q [$];
    bit in_taken = 1'b0;
    int idle_pct = 0, stall_pct = 0, hold_req = 0, hold_seen = 0, hold_cnt = 0;
    int errors = 0, n_results = 0, n_nolines = 0, quiet = 0;

    // predictor state
    logic [19:0] kp = 20'd65536, ki = 20'd82, kd = 20'd2048;
    logic [15:0] target = 16'd717;
    logic [9:0]  period = 10'd10;
    logic [30:0] ilimit = 31'd3276800;
    longint flt [8] = '{default: 0};
    longint prev_err = 0, integ = 0, held = 0;

    line_centroid_pid_steering_core DUT (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(o_ready),
        .i_operation(in_op),
        .i_sensor_0(sens[0]), .i_sensor_1(sens[1]), .i_sensor_2(sens[2]),
        .i_sensor_3(sens[3]), .i_sensor_4(sens[4]), .i_sensor_5(sens[5]),
        .i_sensor_6(sens[6]), .i_sensor_7(sens[7]), .i_feed_speed(speed_in),
        .o_valid(o_valid), .i_ready(out_ready), .o_turn_rate(o_turn_rate),
        .o_forward_speed(o_forward_speed), .o_line_position(o_line_position),
        .o_no_line(o_no_line), .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_idx), .i_cfg_data(cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && ((n < 0) != (d < 0))) q = q - 1;
        return q;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic t_steer steer_step(t_beat b);
        t_steer r;
        longint num, den, s, pos, err, dt, lim, n;
        r.speed = b.speed;
        r.no_line = 1'b0;
        if (b.op == OP_START) begin
            foreach (flt[k]) flt[k] = longint'(b.sens[k]) - BIAS[k];
            integ = 0;
            r.turn = '0;
            r.pos = held[15:0];
            return r;
        end
        num = 0;
        den = 0;
        foreach (flt[k]) begin
            s = longint'(b.sens[k]) - BIAS[k] + flt[k];
            flt[k] = floor_div(s, 2);
            num += flt[k] * k;
            den += flt[k];
        end
        if (den > 0) begin
            pos = clamp(floor_div(num * 1024, den * 5), -32768, 32767);
            held = pos;
        end else begin
            pos = held;
            r.no_line = 1'b1;
        end
        dt = (period == 0) ? 1 : longint'(period);
        err = clamp(pos - longint'(target), -65536, 65535);
        lim = longint'(ilimit);
        integ = clamp(integ + err * dt * 256, -lim, lim);
        n = err * longint'(kp) * 256 * dt + (err - prev_err) * longint'(kd) * 256
          + integ * longint'(ki) * dt;
        r.turn = 32'(clamp(floor_div(-n, dt * 1048576), -64'sd2147483648, 64'sd2147483647));
        prev_err = err;
        r.pos = pos[15:0];
        return r;
    endfunction

    // sender
    always @(negedge clk) begin : drive_beats
        logic nv;
        t_beat b;
        nv = in_valid;
        if (in_valid && in_taken) nv = 1'b0;
        if (rst_n && !nv && beat_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
            b = beat_q.pop_front();
            in_op <= b.op;
            sens <= b.sens;
            speed_in <= b.speed;
            nv = 1'b1;
        end
        in_valid <= nv;
    end

    // receiver, with long hold-off on request
    always @(negedge clk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_cnt <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= rst_n && ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor
    always @(posedge clk) begin : watch_ports
        t_beat b;
        t_steer e;
        in_taken <= in_valid && o_ready;
        if (rst_n) begin
            if (cfg_valid && o_cfg_ready) begin
                case (cfg_idx)
                    CFG_GAIN_P: kp = cfg_data[19:0];
                    CFG_GAIN_I: ki = cfg_data[19:0];
                    CFG_GAIN_D: kd = cfg_data[19:0];
                    CFG_TARGET: target = cfg_data[15:0];
                    CFG_PERIOD: period = cfg_data[9:0];
                    CFG_LIMIT:  ilimit = cfg_data[30:0];
                    default: ;
                endcase
            end
            if (in_valid && o_ready) begin
                b.op = t_op'(in_op);
                b.sens = sens;
                b.speed = speed_in;
                steer_q.push_back(steer_step(b));
            end
            if (o_valid && out_ready) begin
                n_results++;
                if (o_no_line) n_nolines++;
                if (steer_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat turn=%0d", $time, o_turn_rate);
                end else begin
                    e = steer_q.pop_front();
                    if (o_turn_rate !== e.turn) begin
                        errors++;
                        $display("%0t: turn_rate exp %0d got %0d", $time, e.turn, o_turn_rate);
                    end
                    if (o_forward_speed !== e.speed) begin
                        errors++;
                        $display("%0t: forward_speed exp %0d got %0d", $time, e.speed,
                                 o_forward_speed);
                    end
                    if (o_line_position !== e.pos) begin
                        errors++;
                        $display("%0t: line_position exp %0d got %0d", $time, e.pos,
                                 o_line_position);
                    end
                    if (o_no_line !== e.no_line) begin
                        errors++;
                        $display("%0t: no_line exp %0b got %0b", $time, e.no_line, o_no_line);
                    end
                end
            end
            if ((in_valid && o_ready) || (o_valid && out_ready) || (cfg_valid && o_cfg_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= STALL_LIMIT) begin
                $display("timeout at %0t", $time);
                $display("line_centroid_pid_steering_core test failed");
                $finish;
            end
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!o_cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic cfg_all(logic [31:0] p, logic [31:0] i, logic [31:0] d, logic [31:0] t,
                           logic [31:0] dt, logic [31:0] lim);
        cfg_write(CFG_GAIN_P, p);
        cfg_write(CFG_GAIN_I, i);
        cfg_write(CFG_GAIN_D, d);
        cfg_write(CFG_TARGET, t);
        cfg_write(CFG_PERIOD, dt);
        cfg_write(CFG_LIMIT, lim);
    endtask

    task automatic drain();
        while (beat_q.size() != 0 || in_valid || steer_q.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    function automatic t_beat make_beat(t_op op, int shape);
        t_beat b;
        int peak;
        b.op = op;
        b.speed = 16'($urandom());
        peak = $urandom_range(7);
        foreach (b.sens[k]) begin
            case (shape)
                0: b.sens[k] = 12'($urandom());
                1: b.sens[k] = (k == peak || k == peak + 1) ? 12'($urandom_range(4095, 1500))
                                                            : 12'($urandom_range(150));
                2: b.sens[k] = 12'($urandom_range(160));
                default: b.sens[k] = $urandom_range(1) ? 12'hFFF : 12'h000;
            endcase
        end
        return b;
    endfunction

    function automatic t_beat uniform(t_op op, logic [11:0] v, logic [15:0] spd);
        t_beat b;
        b.op = op;
        b.speed = spd;
        foreach (b.sens[k]) b.sens[k] = v;
        return b;
    endfunction

    task automatic add_random(int count);
        int left, run;
        left = count;
        while (left > 0) begin
            if ($urandom_range(9) == 0) begin
                beat_q.push_back(make_beat(t_op'($urandom_range(1)), $urandom_range(3)));
                left--;
            end else begin
                beat_q.push_back(make_beat(OP_START, $urandom_range(3)));
                run = $urandom_range(40, 4);
                left -= run + 1;
                repeat (run) beat_q.push_back(make_beat(OP_SAMPLE,
                                              ($urandom_range(9) < 7) ? 1 : $urandom_range(3)));
            end
        end
    endtask

    initial begin : stimulus
        t_beat b;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, no line, start/sample, peaks at both ends
        beat_q.push_back(uniform(OP_SAMPLE, 12'h000, 16'h0000));
        beat_q.push_back(uniform(OP_START, 12'hFFF, 16'hFFFF));
        beat_q.push_back(uniform(OP_SAMPLE, 12'hFFF, 16'h0000));
        beat_q.push_back(uniform(OP_SAMPLE, 12'h000, 16'hFFFF));
        beat_q.push_back(uniform(OP_SAMPLE, 12'h000, 16'h1234));
        beat_q.push_back(uniform(OP_START, 12'h000, 16'h8000));
        beat_q.push_back(uniform(OP_SAMPLE, 12'h000, 16'h0001));
        b = uniform(OP_START, 12'h000, 16'h00FF);
        b.sens[7] = 12'hFFF;
        beat_q.push_back(b);
        b.op = OP_SAMPLE;
        beat_q.push_back(b);
        b = uniform(OP_START, 12'h000, 16'h7FFF);
        b.sens[0] = 12'hFFF;
        beat_q.push_back(b);
        b.op = OP_SAMPLE;
        beat_q.push_back(b);
        beat_q.push_back(b);
        beat_q.push_back(uniform(OP_SAMPLE, 12'd96, 16'hAAAA));
        beat_q.push_back(uniform(OP_SAMPLE, 12'hFFF, 16'h5555));
        drain();

        // phase 1: max gains, zero period, wide limit; no idling
        cfg_all(32'hFFFFFFFF, 32'h000FFFFF, 32'h000FFFFF, 32'd0, 32'd0, 32'hFFFFFFFF);
        cfg_write(CFG_SPARE_6, $urandom());
        add_random(300);
        drain();

        // phase 2: zero gains/limit, far target, long period; sender idles
        idle_pct = 85;
        cfg_all(32'd0, 32'd0, 32'd0, 32'h0000FFFF, 32'd1000, 32'd0);
        cfg_write(CFG_SPARE_7, $urandom());
        add_random(300);
        drain();

        // phase 3: random settings; receiver stalls, then a long hold-off
        idle_pct = 0;
        stall_pct = 85;
        cfg_all($urandom(), $urandom(), $urandom(), $urandom_range(1500), $urandom_range(1000, 1),
                $urandom());
        add_random(300);
        hold_req = 1;
        drain();

        // phase 4: typical settings; both sides idle a little
        idle_pct = 11;
        stall_pct = 11;
        cfg_all(32'd65536, 32'd82, 32'd2048, 32'd717, 32'd10, 32'd3276800);
        add_random(300);
        drain();

        // phase 5: random everything, random idling
        idle_pct = $urandom_range(60);
        stall_pct = $urandom_range(60);
        cfg_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        add_random(300);
        drain();

        $display("covered %0d result beats (%0d without a line) over six gain settings",
                 n_results, n_nolines);
        $display("with sender idling, receiver stalls and a %0d-cycle hold-off", HOLD_CYCLES);
        if (errors == 0 && steer_q.size() == 0)
            $display("line_centroid_pid_steering_core test passed");
        else
            $display("line_centroid_pid_steering_core test failed");
        $finish;
    end
endmodule

>>> sim.f
src/lcp_pkg.sv
src/lcp_lane.sv
src/lcp_merge.sv
src/lcp_divider.sv
src/line_centroid_pid_steering_core.sv
test/tb_line_centroid_pid_steering_core.sv
